// ----- hdl/mips_integer_execute_unit_macros.svh -----
// Assertion helpers included by the execute unit top level.
`ifndef MIPS_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, ignored during reset.
`define MIEU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MIEU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/mieu_pkg.sv -----
// ----------------------------------------------------------------------------
// mieu_pkg
// Types and constants shared by the MIPS32 integer execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mieu_pkg;

   typedef enum logic [4:0] {
      OP_ADDI  = 5'd0,  OP_BEQ  = 5'd1,  OP_BNE  = 5'd2,  OP_BLTZ = 5'd3,
      OP_BGEZ  = 5'd4,  OP_SLTI = 5'd5,  OP_SLTIU = 5'd6, OP_ANDI = 5'd7,
      OP_ORI   = 5'd8,  OP_XORI = 5'd9,  OP_J    = 5'd10, OP_JAL  = 5'd11,
      OP_ADD   = 5'd12, OP_SUB  = 5'd13, OP_MULT = 5'd14, OP_DIV  = 5'd15,
      OP_AND   = 5'd16, OP_OR   = 5'd17, OP_XOR  = 5'd18, OP_NOR  = 5'd19,
      OP_SLT   = 5'd20, OP_JR   = 5'd21, OP_SLL  = 5'd22, OP_SRL  = 5'd23,
      OP_SRA   = 5'd24, OP_MFHI = 5'd25, OP_MFLO = 5'd26, OP_MUL  = 5'd27,
      OP_MTHI  = 5'd28, OP_MTLO = 5'd29, OP_SEXT = 5'd30, OP_NONE = 5'd31
   } opcode_type;

   localparam logic [31:0] SEGMENT_MASK = 32'hf000_0000;
   localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] result_value;
      logic        write_result;
      logic        link_write;
      logic [31:0] next_pc;
      logic        divide_by_zero;
   } rsp_payload_type;

   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [31:0] rs_value;
      logic [31:0] rt_value;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hi;
      logic [31:0] lo;
   } md_rsp_type;

endpackage
`default_nettype wire

// ----- hdl/mieu_req_if.sv -----
// ----------------------------------------------------------------------------
// mieu_req_if
// Instruction channel into the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
interface mieu_req_if;
   logic               valid;
   logic               ready;
   logic [4:0]         opcode;
   logic [31:0]        rs_value;
   logic [31:0]        rt_value;
   logic signed [15:0] immediate;
   logic [4:0]         shift_amount;
   logic [25:0]        jump_target;
   logic [31:0]        pc;
   logic               rotate_select;
   logic               extend_byte;

   modport source (output valid, opcode, rs_value, rt_value, immediate, shift_amount,
                   jump_target, pc, rotate_select, extend_byte, input ready);
   modport sink   (input valid, opcode, rs_value, rt_value, immediate, shift_amount,
                   jump_target, pc, rotate_select, extend_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/mieu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mieu_rsp_if
// Result channel out of the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
interface mieu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        write_result;
   logic        link_write;
   logic [31:0] next_pc;
   logic        divide_by_zero;

   modport source (output valid, result_value, write_result, link_write, next_pc,
                   divide_by_zero, input ready);
   modport sink   (input valid, result_value, write_result, link_write, next_pc,
                   divide_by_zero, output ready);
endinterface
`default_nettype wire

// ----- hdl/mieu_alu.sv -----
// ----------------------------------------------------------------------------
// mieu_alu
// Combinational operations: arithmetic, logic, shifts, compares, branches, jumps, HI/LO reads and sign extension.
// ----------------------------------------------------------------------------
`default_nettype none
module mieu_alu (
   input  wire logic [4:0]         opcode,
   input  wire logic [31:0]        rs_value,
   input  wire logic [31:0]        rt_value,
   input  wire logic signed [15:0] immediate,
   input  wire logic [4:0]         shift_amount,
   input  wire logic [25:0]        jump_target,
   input  wire logic [31:0]        pc,
   input  wire logic               rotate_select,
   input  wire logic               extend_byte,
   input  wire logic [31:0]        hi_value,
   input  wire logic [31:0]        lo_value,
   output mieu_pkg::rsp_payload_type result
);
   import mieu_pkg::*;

   logic [31:0] simm;
   logic [31:0] zimm;
   logic [31:0] branch_pc;
   logic [31:0] jump_pc;
   logic [63:0] rot_word;
   opcode_type  op;

   assign simm      = {{16{immediate[15]}}, immediate};
   assign zimm      = {16'h0000, immediate};
   assign branch_pc = pc + {simm[29:0], 2'b00};
   assign jump_pc   = (pc & SEGMENT_MASK) | {4'h0, jump_target, 2'b00};
   assign rot_word  = {rt_value, rt_value} >> shift_amount;
   assign op        = opcode_type'(opcode);

   always_comb begin
      result = '0;
      result.next_pc = pc;
      case (op)
         OP_ADDI:  begin result.result_value = rs_value + simm; result.write_result = 1'b1; end
         OP_BEQ:   if (rs_value == rt_value) result.next_pc = branch_pc;
         OP_BNE:   if (rs_value != rt_value) result.next_pc = branch_pc;
         OP_BLTZ:  if (rs_value[31]) result.next_pc = branch_pc;
         OP_BGEZ:  if (!rs_value[31]) result.next_pc = branch_pc;
         OP_SLTI: begin
            result.result_value = {31'd0, $signed(rs_value) < $signed(simm)};
            result.write_result = 1'b1;
         end
         OP_SLTIU: begin
            result.result_value = {31'd0, rs_value < simm};
            result.write_result = 1'b1;
         end
         OP_ANDI:  begin result.result_value = rs_value & zimm; result.write_result = 1'b1; end
         OP_ORI:   begin result.result_value = rs_value | zimm; result.write_result = 1'b1; end
         OP_XORI:  begin result.result_value = rs_value ^ zimm; result.write_result = 1'b1; end
         OP_J:     result.next_pc = jump_pc;
         OP_JAL: begin
            result.result_value = pc;
            result.link_write   = 1'b1;
            result.next_pc      = jump_pc;
         end
         OP_ADD:   begin result.result_value = rs_value + rt_value; result.write_result = 1'b1; end
         OP_SUB:   begin result.result_value = rs_value - rt_value; result.write_result = 1'b1; end
         OP_DIV:   result.divide_by_zero = (rt_value == 32'd0);
         OP_AND:   begin result.result_value = rs_value & rt_value; result.write_result = 1'b1; end
         OP_OR:    begin result.result_value = rs_value | rt_value; result.write_result = 1'b1; end
         OP_XOR:   begin result.result_value = rs_value ^ rt_value; result.write_result = 1'b1; end
         OP_NOR: begin
            result.result_value = ~(rs_value | rt_value);
            result.write_result = 1'b1;
         end
         OP_SLT: begin
            result.result_value = {31'd0, $signed(rs_value) < $signed(rt_value)};
            result.write_result = 1'b1;
         end
         OP_JR:    result.next_pc = rs_value;
         OP_SLL: begin
            result.result_value = rt_value << shift_amount;
            result.write_result = 1'b1;
         end
         OP_SRL: begin
            result.result_value = rotate_select ? rot_word[31:0] : rt_value >> shift_amount;
            result.write_result = 1'b1;
         end
         OP_SRA: begin
            result.result_value = $unsigned($signed(rt_value) >>> shift_amount);
            result.write_result = 1'b1;
         end
         OP_MFHI:  begin result.result_value = hi_value; result.write_result = 1'b1; end
         OP_MFLO:  begin result.result_value = lo_value; result.write_result = 1'b1; end
         OP_SEXT: begin
            result.result_value = extend_byte ? {{24{rt_value[7]}}, rt_value[7:0]}
                                              : {{16{rt_value[15]}}, rt_value[15:0]};
            result.write_result = 1'b1;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// ----- hdl/mieu_muldiv.sv -----
// ----------------------------------------------------------------------------
// mieu_muldiv
// Iterative signed multiply and divide on one shared 34-bit adder.
// ----------------------------------------------------------------------------
`default_nettype none
module mieu_muldiv (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mieu_pkg::md_req_type req,
   output mieu_pkg::md_rsp_type     rsp
);
   import mieu_pkg::*;

   typedef enum logic [2:0] {
      MD_IDLE = 3'b001,
      MD_RUN  = 3'b010,
      MD_FIX  = 3'b100
   } md_state_type;

   md_state_type state_ff, state_in;
   logic [4:0]   count_ff, count_in;
   logic         is_div_ff, is_div_in;
   logic         rs_neg_ff, rs_neg_in;
   logic         rt_neg_ff, rt_neg_in;
   logic [31:0]  upper_ff, upper_in;
   logic [31:0]  lower_ff, lower_in;
   logic [31:0]  operand_ff, operand_in;
   logic         done_ff, done_in;
   logic [31:0]  hi_ff, hi_in;
   logic [31:0]  lo_ff, lo_in;

   logic [32:0]  add_x;
   logic [31:0]  add_y;
   logic [33:0]  add_sum;
   logic [32:0]  shifted;
   logic [31:0]  rs_mag;
   logic [31:0]  rt_mag;
   logic [63:0]  product;

   assign rs_mag  = req.rs_value[31] ? 32'd0 - req.rs_value : req.rs_value;
   assign rt_mag  = req.rt_value[31] ? 32'd0 - req.rt_value : req.rt_value;
   assign shifted = {upper_ff, lower_ff[31]};
   assign product = {upper_ff, lower_ff};

   // The shared adder: add for multiply steps, subtract for divide steps.
   always_comb begin
      if (is_div_ff) begin
         add_x = shifted;
         add_y = operand_ff;
      end else begin
         add_x = {1'b0, upper_ff};
         add_y = lower_ff[0] ? operand_ff : 32'd0;
      end
      add_sum = {1'b0, add_x} + (is_div_ff ? ~{2'b00, add_y} + 34'd1 : {2'b00, add_y});
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      is_div_in  = is_div_ff;
      rs_neg_in  = rs_neg_ff;
      rt_neg_in  = rt_neg_ff;
      upper_in   = upper_ff;
      lower_in   = lower_ff;
      operand_in = operand_ff;
      done_in    = 1'b0;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      case (state_ff)
         MD_IDLE: if (req.start) begin
            state_in   = MD_RUN;
            count_in   = '1;
            is_div_in  = req.is_div;
            rs_neg_in  = req.rs_value[31];
            rt_neg_in  = req.rt_value[31];
            upper_in   = '0;
            lower_in   = req.is_div ? rs_mag : rt_mag;
            operand_in = req.is_div ? rt_mag : rs_mag;
         end
         MD_RUN: begin
            if (is_div_ff) begin
               if (!add_sum[33]) begin
                  upper_in = add_sum[31:0];
               end else begin
                  upper_in = shifted[31:0];
               end
               lower_in = {lower_ff[30:0], ~add_sum[33]};
            end else begin
               upper_in = add_sum[32:1];
               lower_in = {add_sum[0], lower_ff[31:1]};
            end
            count_in = count_ff - 5'd1;
            if (count_ff == 5'd0) state_in = MD_FIX;
         end
         MD_FIX: begin
            if (is_div_ff) begin
               lo_in = (rs_neg_ff ^ rt_neg_ff) ? 32'd0 - lower_ff : lower_ff;
               hi_in = rs_neg_ff ? 32'd0 - upper_ff : upper_ff;
            end else begin
               {hi_in, lo_in} = (rs_neg_ff ^ rt_neg_ff) ? 64'd0 - product : product;
            end
            done_in  = 1'b1;
            state_in = MD_IDLE;
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      count_ff   <= count_in;
      is_div_ff  <= is_div_in;
      rs_neg_ff  <= rs_neg_in;
      rt_neg_ff  <= rt_neg_in;
      upper_ff   <= upper_in;
      lower_ff   <= lower_in;
      operand_ff <= operand_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.hi   = hi_ff;
   assign rsp.lo   = lo_ff;
endmodule
`default_nettype wire

// ----- hdl/mips_integer_execute_unit.sv -----
// Multiply (mult, mul) and divide with a nonzero divisor go from transfer to
// result through one load, 32 steps of the shared adder, one sign fix and one
// result load, and hold off the next transfer until their result is loaded.
// Other work: one instruction per cycle while the result side does not stall.
// Reset clears HI, LO, the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
// mips_integer_execute_unit
// MIPS32 integer execute stage with HI/LO and an iterative multiply/divide.
// ----------------------------------------------------------------------------
`default_nettype none
module mips_integer_execute_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   mieu_req_if.sink    req_channel,
   mieu_rsp_if.source  rsp_channel
);
   import mieu_pkg::*;
   `include "mips_integer_execute_unit_macros.svh"

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WAIT = 2'b10
   } state_type;

   state_type       state_ff, state_in;
   logic [31:0]     hi_ff, hi_in;
   logic [31:0]     lo_ff, lo_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            is_mul_ff, is_mul_in;
   logic            keep_hilo_ff, keep_hilo_in;
   logic [31:0]     pend_pc_ff, pend_pc_in;

   rsp_payload_type alu_result;
   md_req_type      md_req;
   md_rsp_type      md_rsp;
   opcode_type      op;
   logic            accept;
   logic            long_op;
   logic            out_free;

   assign op       = opcode_type'(req_channel.opcode);
   assign out_free = !rsp_valid_ff || rsp_channel.ready;
   assign req_channel.ready = (state_ff == ST_IDLE) && out_free;
   assign accept   = req_channel.valid && req_channel.ready;
   assign long_op  = (op == OP_MULT) || (op == OP_MUL)
                  || ((op == OP_DIV) && (req_channel.rt_value != 32'd0));

   mieu_alu u_alu (
      .opcode        (req_channel.opcode),
      .rs_value      (req_channel.rs_value),
      .rt_value      (req_channel.rt_value),
      .immediate     (req_channel.immediate),
      .shift_amount  (req_channel.shift_amount),
      .jump_target   (req_channel.jump_target),
      .pc            (req_channel.pc),
      .rotate_select (req_channel.rotate_select),
      .extend_byte   (req_channel.extend_byte),
      .hi_value      (hi_ff),
      .lo_value      (lo_ff),
      .result        (alu_result)
   );

   assign md_req.start    = accept && long_op;
   assign md_req.is_div   = (op == OP_DIV);
   assign md_req.rs_value = req_channel.rs_value;
   assign md_req.rt_value = req_channel.rt_value;

   mieu_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      is_mul_in    = is_mul_ff;
      keep_hilo_in = keep_hilo_ff;
      pend_pc_in   = pend_pc_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            if (long_op) begin
               state_in     = ST_WAIT;
               is_mul_in    = (op == OP_MUL);
               keep_hilo_in = (op == OP_MUL);
               pend_pc_in   = req_channel.pc;
            end else begin
               rsp_in       = alu_result;
               rsp_valid_in = 1'b1;
               if (op == OP_MTHI) hi_in = req_channel.rs_value;
               if (op == OP_MTLO) lo_in = req_channel.rs_value;
            end
         end
         ST_WAIT: if (md_rsp.done) begin
            // The output register is empty here: no transfer was taken while waiting.
            state_in                = ST_IDLE;
            rsp_in                  = '0;
            rsp_in.next_pc          = pend_pc_ff;
            rsp_in.write_result     = is_mul_ff;
            rsp_in.result_value     = is_mul_ff ? md_rsp.lo : 32'd0;
            rsp_valid_in            = 1'b1;
            if (!keep_hilo_ff) begin
               hi_in = md_rsp.hi;
               lo_in = md_rsp.lo;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hi_ff        <= '0;
         lo_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff       <= rsp_in;
      is_mul_ff    <= is_mul_in;
      keep_hilo_ff <= keep_hilo_in;
      pend_pc_ff   <= pend_pc_in;
   end

   assign rsp_channel.valid          = rsp_valid_ff;
   assign rsp_channel.result_value   = rsp_ff.result_value;
   assign rsp_channel.write_result   = rsp_ff.write_result;
   assign rsp_channel.link_write     = rsp_ff.link_write;
   assign rsp_channel.next_pc        = rsp_ff.next_pc;
   assign rsp_channel.divide_by_zero = rsp_ff.divide_by_zero;

   `MIEU_ASSERT_NEXT(a_long_op_waits, md_req.start, state_ff == ST_WAIT,
      "multiply or divide did not enter the wait state")
   `MIEU_ASSERT_NOW(a_done_only_waiting, md_rsp.done, state_ff == ST_WAIT && !rsp_valid_ff,
      "multiply/divide finished while not waiting or with the output register full")
   `MIEU_ASSERT_NOW(a_dz_writes_nothing, rsp_valid_ff && rsp_ff.divide_by_zero,
      !rsp_ff.write_result && !rsp_ff.link_write,
      "divide by zero result carries a register write")
endmodule
`default_nettype wire

// ----- tb/mips_integer_execute_unit_tb.sv -----
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_tb
// Self-checking bench for the integer execute unit. A directed table covers
// the field extremes, every opcode and the awkward divide and shift cases. A
// random part follows under several idling patterns. Each result transfer is
// checked field by field against a local model that keeps its own HI and LO.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mieu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [4:0]         opcode;
      logic [31:0]        rs_value;
      logic [31:0]        rt_value;
      logic signed [15:0] immediate;
      logic [4:0]         shift_amount;
      logic [25:0]        jump_target;
      logic [31:0]        pc;
      logic               rotate_select;
      logic               extend_byte;
   } instr_type;

   // A directed row, with an optional hand-written expected result.
   typedef struct packed {
      instr_type       instr;
      logic            has_known;
      rsp_payload_type known;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mieu_req_if req_channel ();
   mieu_rsp_if rsp_channel ();

   mips_integer_execute_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel.sink),
      .rsp_channel (rsp_channel.source)
   );

   always #6 clock = ~clock;

   logic [31:0]     model_hi = '0;
   logic [31:0]     model_lo = '0;
   rsp_payload_type pending_results[$];
   int              mismatch_count = 0;
   int              result_count   = 0;
   int              idle_cycles    = 0;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;

   function automatic rsp_payload_type execute_instr(input instr_type i);
      rsp_payload_type r;
      logic [31:0]        simm, zimm, branch_pc, ua, ub, q, rem;
      logic [63:0]        rot_word;
      logic signed [63:0] prod;
      logic               rs_neg, rt_neg;
      r = '0;
      r.next_pc = i.pc;
      simm = {{16{i.immediate[15]}}, i.immediate};
      zimm = {16'h0000, i.immediate};
      branch_pc = i.pc + (simm << 2);
      rs_neg = i.rs_value[31];
      rt_neg = i.rt_value[31];
      prod = $signed(i.rs_value) * $signed(i.rt_value);
      rot_word = {i.rt_value, i.rt_value} >> i.shift_amount;
      case (opcode_type'(i.opcode))
         OP_ADDI: begin r.result_value = i.rs_value + simm; r.write_result = 1; end
         OP_BEQ:  if (i.rs_value == i.rt_value) r.next_pc = branch_pc;
         OP_BNE:  if (i.rs_value != i.rt_value) r.next_pc = branch_pc;
         OP_BLTZ: if (rs_neg) r.next_pc = branch_pc;
         OP_BGEZ: if (!rs_neg) r.next_pc = branch_pc;
         OP_SLTI: begin
            r.result_value = ($signed(i.rs_value) < $signed(simm)) ? 1 : 0;
            r.write_result = 1;
         end
         OP_SLTIU: begin r.result_value = (i.rs_value < simm) ? 1 : 0; r.write_result = 1; end
         OP_ANDI: begin r.result_value = i.rs_value & zimm; r.write_result = 1; end
         OP_ORI:  begin r.result_value = i.rs_value | zimm; r.write_result = 1; end
         OP_XORI: begin r.result_value = i.rs_value ^ zimm; r.write_result = 1; end
         OP_J:    r.next_pc = (i.pc & SEGMENT_MASK) | {4'h0, i.jump_target, 2'b00};
         OP_JAL: begin
            r.result_value = i.pc;
            r.link_write = 1;
            r.next_pc = (i.pc & SEGMENT_MASK) | {4'h0, i.jump_target, 2'b00};
         end
         OP_ADD: begin r.result_value = i.rs_value + i.rt_value; r.write_result = 1; end
         OP_SUB: begin r.result_value = i.rs_value - i.rt_value; r.write_result = 1; end
         OP_MULT: begin model_hi = prod[63:32]; model_lo = prod[31:0]; end
         OP_DIV: begin
            if (i.rt_value == 0) begin
               r.divide_by_zero = 1;
            end else begin
               ua = rs_neg ? -i.rs_value : i.rs_value;
               ub = rt_neg ? -i.rt_value : i.rt_value;
               q = ua / ub;
               rem = ua % ub;
               model_lo = (rs_neg != rt_neg) ? -q : q;
               model_hi = rs_neg ? -rem : rem;
            end
         end
         OP_AND: begin r.result_value = i.rs_value & i.rt_value; r.write_result = 1; end
         OP_OR:  begin r.result_value = i.rs_value | i.rt_value; r.write_result = 1; end
         OP_XOR: begin r.result_value = i.rs_value ^ i.rt_value; r.write_result = 1; end
         OP_NOR: begin r.result_value = ~(i.rs_value | i.rt_value); r.write_result = 1; end
         OP_SLT: begin
            r.result_value = ($signed(i.rs_value) < $signed(i.rt_value)) ? 1 : 0;
            r.write_result = 1;
         end
         OP_JR:  r.next_pc = i.rs_value;
         OP_SLL: begin r.result_value = i.rt_value << i.shift_amount; r.write_result = 1; end
         OP_SRL: begin
            r.result_value = i.rotate_select ? rot_word[31:0] : (i.rt_value >> i.shift_amount);
            r.write_result = 1;
         end
         OP_SRA: begin
            r.result_value = $signed(i.rt_value) >>> i.shift_amount;
            r.write_result = 1;
         end
         OP_MFHI: begin r.result_value = model_hi; r.write_result = 1; end
         OP_MFLO: begin r.result_value = model_lo; r.write_result = 1; end
         OP_MUL:  begin r.result_value = prod[31:0]; r.write_result = 1; end
         OP_MTHI: model_hi = i.rs_value;
         OP_MTLO: model_lo = i.rs_value;
         OP_SEXT: begin
            r.result_value = i.extend_byte ? {{24{i.rt_value[7]}}, i.rt_value[7:0]} :
                                             {{16{i.rt_value[15]}}, i.rt_value[15:0]};
            r.write_result = 1;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: %s got %h, expected %h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   function automatic instr_type make_instr(input opcode_type op, input logic [31:0] rs,
                                            input logic [31:0] rt);
      instr_type i;
      i = '0;
      i.opcode = op;
      i.rs_value = rs;
      i.rt_value = rt;
      i.pc = 32'h0040_0004;
      return i;
   endfunction

   function automatic instr_type random_instr();
      instr_type i;
      int        pick;
      i.opcode = 5'($urandom_range(0, 31));
      i.rs_value = $urandom;
      i.rt_value = $urandom;
      pick = $urandom_range(0, 9);
      // Bias the operands towards the values that upset dividers and comparators.
      if (pick == 0) i.rt_value = 0;
      if (pick == 1) begin i.rs_value = SIGN_BIT; i.rt_value = '1; end
      if (pick == 2) i.rt_value = i.rs_value;
      if (pick == 3) i.rs_value = $urandom_range(0, 40) - 20;
      if (pick == 4) i.rt_value = $urandom_range(0, 40) - 20;
      i.immediate = 16'($urandom);
      i.shift_amount = 5'($urandom);
      i.jump_target = 26'($urandom);
      i.pc = $urandom;
      i.rotate_select = 1'($urandom);
      i.extend_byte = 1'($urandom);
      return i;
   endfunction

   // Result side: random stalls and the checks.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_channel.ready <= 1'b0;
      end else begin
         rsp_channel.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         if (rsp_channel.valid && rsp_channel.ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
               $display("ERROR %0t: result transfer with nothing outstanding", $realtime);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_channel.result_value !== want.result_value)
                  report_mismatch("result_value", rsp_channel.result_value, want.result_value);
               if (rsp_channel.write_result !== want.write_result)
                  report_mismatch("write_result", 32'(rsp_channel.write_result),
                                  32'(want.write_result));
               if (rsp_channel.link_write !== want.link_write)
                  report_mismatch("link_write", 32'(rsp_channel.link_write),
                                  32'(want.link_write));
               if (rsp_channel.next_pc !== want.next_pc)
                  report_mismatch("next_pc", rsp_channel.next_pc, want.next_pc);
               if (rsp_channel.divide_by_zero !== want.divide_by_zero)
                  report_mismatch("divide_by_zero", 32'(rsp_channel.divide_by_zero),
                                  32'(want.divide_by_zero));
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_channel.valid && req_channel.ready) ||
          (rsp_channel.valid && rsp_channel.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Drives one instruction, idling first at the current rate, and waits for
   // its transfer. The expectation is queued at the transfer edge. Valid stays
   // high afterwards so that the next instruction can follow with no gap.
   task automatic send_instr(input instr_type i, input logic has_known,
                             input rsp_payload_type known);
      rsp_payload_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_channel.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_channel.valid         <= 1'b1;
      req_channel.opcode        <= i.opcode;
      req_channel.rs_value      <= i.rs_value;
      req_channel.rt_value      <= i.rt_value;
      req_channel.immediate     <= i.immediate;
      req_channel.shift_amount  <= i.shift_amount;
      req_channel.jump_target   <= i.jump_target;
      req_channel.pc            <= i.pc;
      req_channel.rotate_select <= i.rotate_select;
      req_channel.extend_byte   <= i.extend_byte;
      do @(posedge clock); while (!req_channel.ready);
      predicted = execute_instr(i);
      if (has_known && predicted !== known) begin
         $display("ERROR: directed row for opcode %0d disagrees with the model", i.opcode);
         mismatch_count++;
      end
      pending_results.push_back(has_known ? known : predicted);
   endtask

   task automatic drain_results();
      req_channel.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      row_type   rows[$];
      row_type   row;
      instr_type i;
      int        phase, n;

      req_channel.valid <= 1'b0;
      req_channel.opcode <= '0;
      req_channel.rs_value <= '0;
      req_channel.rt_value <= '0;
      req_channel.immediate <= '0;
      req_channel.shift_amount <= '0;
      req_channel.jump_target <= '0;
      req_channel.pc <= '0;
      req_channel.rotate_select <= 1'b0;
      req_channel.extend_byte <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Rows with has_known carry a result read off directly.
      row = '0; row.instr = make_instr(OP_MFHI, 0, 0); row.has_known = 1;
      row.known = '{32'h0, 1'b1, 1'b0, 32'h0040_0004, 1'b0}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_MFLO, 0, 0); row.has_known = 1;
      row.known = '{32'h0, 1'b1, 1'b0, 32'h0040_0004, 1'b0}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_ADD, 32'hffff_ffff, 32'h1); row.has_known = 1;
      row.known = '{32'h0, 1'b1, 1'b0, 32'h0040_0004, 1'b0}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_SUB, 32'h8000_0000, 32'h1); rows.push_back(row);
      row = '0; row.instr = make_instr(OP_ADDI, 32'h7fff_ffff, 0);
      row.instr.immediate = 16'sh7fff; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_DIV, 32'h1234, 0); row.has_known = 1;
      row.known = '{32'h0, 1'b0, 1'b0, 32'h0040_0004, 1'b1}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_DIV, 32'h8000_0000, 32'hffff_ffff); rows.push_back(row);
      row = '0; row.instr = make_instr(OP_MFLO, 0, 0); row.has_known = 1;
      row.known = '{32'h8000_0000, 1'b1, 1'b0, 32'h0040_0004, 1'b0}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_MFHI, 0, 0); row.has_known = 1;
      row.known = '{32'h0, 1'b1, 1'b0, 32'h0040_0004, 1'b0}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_DIV, 32'hffff_fff9, 32'h2); rows.push_back(row);
      row = '0; row.instr = make_instr(OP_MFHI, 0, 0); rows.push_back(row);
      row = '0; row.instr = make_instr(OP_MULT, 32'h8000_0000, 32'h8000_0000); rows.push_back(row);
      row = '0; row.instr = make_instr(OP_MFHI, 0, 0); rows.push_back(row);
      row = '0; row.instr = make_instr(OP_MUL, 32'hffff_ffff, 32'h7fff_ffff); rows.push_back(row);
      row = '0; row.instr = make_instr(OP_SRL, 0, 32'h8000_0001);
      row.instr.rotate_select = 1; row.has_known = 1;
      row.known = '{32'h8000_0001, 1'b1, 1'b0, 32'h0040_0004, 1'b0}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_SRA, 0, 32'h8000_0000);
      row.instr.shift_amount = 31; row.has_known = 1;
      row.known = '{32'hffff_ffff, 1'b1, 1'b0, 32'h0040_0004, 1'b0}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_SLTIU, 32'hffff_fffe, 0);
      row.instr.immediate = -16'sd1; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_ORI, 0, 0); row.instr.immediate = 16'sh8000;
      row.has_known = 1; row.known = '{32'h8000, 1'b1, 1'b0, 32'h0040_0004, 1'b0};
      rows.push_back(row);
      row = '0; row.instr = make_instr(OP_BEQ, 5, 5); row.instr.immediate = 16'sh8000;
      rows.push_back(row);
      row = '0; row.instr = make_instr(OP_JAL, 0, 0); row.instr.pc = 32'hffff_fffc;
      row.instr.jump_target = 26'h3ff_ffff; row.has_known = 1;
      row.known = '{32'hffff_fffc, 1'b0, 1'b1, 32'hffff_fffc, 1'b0}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_SEXT, 0, 32'h0000_0080);
      row.instr.extend_byte = 1; row.has_known = 1;
      row.known = '{32'hffff_ff80, 1'b1, 1'b0, 32'h0040_0004, 1'b0}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_NONE, 32'hffff_ffff, 32'hffff_ffff); row.has_known = 1;
      row.known = '{32'h0, 1'b0, 1'b0, 32'h0040_0004, 1'b0}; rows.push_back(row);
      row = '0; row.instr = make_instr(OP_JR, 32'hdead_beef, 0); rows.push_back(row);
      // Every opcode once with random operands.
      for (int op = 0; op < 32; op++) begin
         row = '0; row.instr = random_instr(); row.instr.opcode = 5'(op); rows.push_back(row);
      end
      foreach (rows[k]) send_instr(rows[k].instr, rows[k].has_known, rows[k].known);
      drain_results();

      // Random part across the idling patterns.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         for (n = 0; n < 150; n++) begin
            i = random_instr();
            send_instr(i, 1'b0, '0);
            if (n == 75) drain_results();
         end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain_results();
      repeat (40) @(posedge clock);

      $display("Ran %0d directed rows and 600 random instructions over four idling patterns;",
               rows.size());
      $display("%0d results checked, HI/LO tracked through mult, div and moves.", result_count);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/mieu_pkg.sv
hdl/mieu_req_if.sv
hdl/mieu_rsp_if.sv
hdl/mieu_alu.sv
hdl/mieu_muldiv.sv
hdl/mips_integer_execute_unit.sv
tb/mips_integer_execute_unit_tb.sv
